// ===== rtl/tslne_pkg.sv =====
// Shared constants, types and helper functions for the line-number / escape filter.
package tslne_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int BCD_W         = 4 * NUMBER_DIGITS;
    localparam int NCNT_W        = $clog2(NUMBER_DIGITS + 2);
    localparam int BODY_MAX      = 4;
    localparam int BLEN_W        = 3;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_EMPTY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

    // numbering modes
    localparam logic [1:0] NUM_OFF      = 2'd0;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_HIGH   = 8'h80;
    localparam logic [7:0] CH_MHIGH  = 8'hA0;
    localparam logic [7:0] CH_FF     = 8'hFF;
    localparam logic [7:0] OFS_CTRL  = 8'h40;

    // one classified request handed from front to back
    typedef struct packed {
        logic                           has_num;
        logic [NUMBER_DIGITS-1:0]       blank;     // leading-space mask, per digit
        logic [BCD_W-1:0]               digits;
        logic [BLEN_W-1:0]              body_len;  // 1..BODY_MAX
        logic [BODY_MAX-1:0][7:0]       body;      // body[0] goes out first
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // saturating BCD increment
    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             all9;
        logic             carry;
        r     = v;
        all9  = 1'b1;
        carry = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd9) all9 = 1'b0;
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry) begin
                if (v[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return all9 ? v : r;
    endfunction

    // bit k set when digit k prints as a leading space
    function automatic logic [NUMBER_DIGITS-1:0] lead_blank(input logic [BCD_W-1:0] v);
        logic [NUMBER_DIGITS-1:0] m;
        logic                     seen;
        m    = '0;
        seen = 1'b0;
        for (int i = NUMBER_DIGITS - 1; i > 0; i--) begin
            seen = seen | (v[4*i +: 4] != 4'd0);
            m[i] = ~seen;
        end
        return m;
    endfunction

endpackage

// ===== rtl/tslne_front.sv =====
// Front end: config registers, line state, and classification of each input byte.
module tslne_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [tslne_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tslne_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                        i_push,
    input  logic [7:0]                  i_in_byte,
    input  tslne_pkg::t_fifo_stat       i_fifo_stat,
    output logic                        o_cmd_push,
    output tslne_pkg::t_cmd             o_cmd
);
    import tslne_pkg::*;

    logic [1:0]       r_number_mode;
    logic             r_squeeze_empty;
    logic             r_show_ends;
    logic             r_show_tabs;
    logic             r_show_nonprinting;

    logic [BCD_W-1:0] r_bcd;
    logic             r_at_start;
    logic [1:0]       r_empty_run;

    logic             accept;
    logic             is_nl;
    logic             is_tab;
    logic             nonprint;
    logic [1:0]       n_empty_run;
    logic             drop;
    logic             do_num;
    logic [7:0]       c;

    assign c      = i_in_byte;
    assign accept = i_push & ~i_fifo_stat.full;
    assign is_nl  = (c == CH_NL);
    assign is_tab = (c == CH_TAB);
    assign nonprint = ~(((c >= CH_SPACE) && (c <= CH_TILDE)) || is_nl || is_tab);

    always_comb begin
        if (is_nl) begin
            n_empty_run = (r_at_start && (r_empty_run < 2'd2)) ? r_empty_run + 2'd1
                                                                : r_empty_run;
        end else begin
            n_empty_run = 2'd0;
        end
    end

    assign drop   = r_squeeze_empty & (n_empty_run >= 2'd2);
    assign do_num = r_at_start && (r_number_mode[0] ||
                    ((r_number_mode == NUM_NONBLANK) && (n_empty_run == 2'd0)));

    always_comb begin
        o_cmd          = '0;
        o_cmd.has_num  = do_num;
        o_cmd.digits   = r_bcd;
        o_cmd.blank    = lead_blank(r_bcd);
        if (r_show_nonprinting && nonprint) begin
            priority if (c == CH_FF) begin
                o_cmd.body     = {CH_QMARK, CH_CARET, CH_DASH, CH_M};
                o_cmd.body_len = 3'd4;
            end else if (c >= CH_MHIGH) begin
                o_cmd.body     = {8'h00, {1'b0, c[6:0]}, CH_DASH, CH_M};
                o_cmd.body_len = 3'd3;
            end else if (c >= CH_HIGH) begin
                o_cmd.body     = {8'(c - OFS_CTRL), CH_CARET, CH_DASH, CH_M};
                o_cmd.body_len = 3'd4;
            end else if (c == CH_DEL) begin
                o_cmd.body     = {16'h0000, CH_QMARK, CH_CARET};
                o_cmd.body_len = 3'd2;
            end else begin
                o_cmd.body     = {16'h0000, 8'(c + OFS_CTRL), CH_CARET};
                o_cmd.body_len = 3'd2;
            end
        end else begin
            priority if (r_show_ends && is_nl) begin
                o_cmd.body     = {16'h0000, CH_NL, CH_DOLLAR};
                o_cmd.body_len = 3'd2;
            end else if (r_show_tabs && is_tab) begin
                o_cmd.body     = {16'h0000, CH_I, CH_CARET};
                o_cmd.body_len = 3'd2;
            end else begin
                o_cmd.body     = {24'h000000, c};
                o_cmd.body_len = 3'd1;
            end
        end
    end

    assign o_cmd_push = accept & ~drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_mode      <= NUM_OFF;
            r_squeeze_empty    <= 1'b0;
            r_show_ends        <= 1'b0;
            r_show_tabs        <= 1'b0;
            r_show_nonprinting <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_NUMBER_MODE:      r_number_mode      <= i_cfg_data[1:0];
                REG_SQUEEZE_EMPTY:    r_squeeze_empty    <= i_cfg_data[0];
                REG_SHOW_ENDS:        r_show_ends        <= i_cfg_data[0];
                REG_SHOW_TABS:        r_show_tabs        <= i_cfg_data[0];
                REG_SHOW_NONPRINTING: r_show_nonprinting <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcd       <= BCD_W'(1);
            r_at_start  <= 1'b1;
            r_empty_run <= 2'd0;
        end else if (accept) begin
            r_empty_run <= n_empty_run;
            r_at_start  <= is_nl;
            if (!drop && do_num) begin
                r_bcd <= bcd_inc(r_bcd);
            end
        end
    end

endmodule

// ===== rtl/tslne_cmd_fifo.sv =====
// Short request queue between front and back ends.
module tslne_cmd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tslne_pkg::t_cmd       i_cmd,
    input  logic                  i_pop,
    output tslne_pkg::t_cmd       o_cmd,
    output tslne_pkg::t_fifo_stat o_stat
);
    import tslne_pkg::*;

    t_cmd                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_AW:0]     r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_stat.full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_cmd        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/tslne_back.sv =====
// Back end: walks one request byte by byte into the output register.
module tslne_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tslne_pkg::t_cmd       i_cmd,
    input  tslne_pkg::t_fifo_stat i_fifo_stat,
    output logic                  o_cmd_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_out_byte,
    output logic                  o_last
);
    import tslne_pkg::*;

    logic                         r_act;
    logic [NCNT_W-1:0]            r_num_cnt;   // number bytes left, tab included
    logic [BCD_W-1:0]             r_digits;
    logic [NUMBER_DIGITS-1:0]     r_blank;
    logic [BLEN_W-1:0]            r_body_cnt;
    logic [BODY_MAX-1:0][7:0]     r_body;
    logic                         r_out_vld;
    logic [7:0]                   r_out_byte;
    logic                         r_out_last;

    logic                         advance;
    logic                         emit;
    logic [7:0]                   cur_byte;
    logic                         cur_last;

    assign advance = ~r_out_vld | i_pop;
    assign emit    = r_act & advance;

    always_comb begin
        priority if (r_num_cnt > NCNT_W'(1)) begin
            cur_byte = r_blank[NUMBER_DIGITS-1] ? CH_SPACE
                                                : CH_ZERO + {4'd0, r_digits[BCD_W-1 -: 4]};
        end else if (r_num_cnt == NCNT_W'(1)) begin
            cur_byte = CH_TAB;
        end else begin
            cur_byte = r_body[0];
        end
    end

    assign cur_last  = (r_num_cnt == '0) && (r_body_cnt == BLEN_W'(1));
    assign o_cmd_pop = ~i_fifo_stat.empty & (~r_act | (emit & cur_last));

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_num_cnt  <= i_cmd.has_num ? NCNT_W'(NUMBER_DIGITS + 1) : '0;
            r_digits   <= i_cmd.digits;
            r_blank    <= i_cmd.blank;
            r_body_cnt <= i_cmd.body_len;
            r_body     <= i_cmd.body;
        end else if (emit) begin
            if (r_num_cnt != '0) begin
                r_num_cnt <= r_num_cnt - 1'b1;
                r_digits  <= {r_digits[BCD_W-5:0], 4'd0};
                r_blank   <= {r_blank[NUMBER_DIGITS-2:0], 1'b0};
            end else begin
                r_body_cnt <= r_body_cnt - 1'b1;
                r_body     <= {8'h00, r_body[BODY_MAX-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (o_cmd_pop) begin
            r_act <= 1'b1;
        end else if (emit && cur_last) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= cur_last;
        end
    end

    assign o_empty    = ~r_out_vld;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

// ===== rtl/text_stream_line_number_escaper.sv =====
// Top level of the line-numbering, empty-line-squeezing and visible-escape text filter.
// First result byte path: request queue, back-end sequencer, output register.
// Throughput: the back-end sequencer emits one byte per cycle unless i_pop stalls, so
//   one-byte requests sustain 1 per cycle; a numbered line start adds 7 bytes.
// Input stalls (o_full) only when the 4-entry request queue fills behind the sequencer.
// Reset (sync, active low): counter to 1, at line start, config cleared, queue empty.
module text_stream_line_number_escaper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_wr_en,
    input  logic [tslne_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tslne_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input queue side
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [7:0]                          i_in_byte,
    // result queue side
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [7:0]                          o_out_byte,
    output logic                                o_last
);
    import tslne_pkg::*;

    // Front end updates line state and classifies each byte into a request:
    // optional line number snapshot plus up to four body bytes.
    // Squeezed newlines never make a request at all.
    t_cmd       front_cmd;
    logic       front_push;
    t_cmd       fifo_cmd;
    t_fifo_stat fifo_stat;
    logic       back_pop;

    tslne_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_in_byte   (i_in_byte),
        .i_fifo_stat (fifo_stat),
        .o_cmd_push  (front_push),
        .o_cmd       (front_cmd)
    );

    // Decouples the per-byte front from the back end's byte-by-byte expansions.
    tslne_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_cmd   (fifo_cmd),
        .o_stat  (fifo_stat)
    );

    // Back end emits one byte per cycle into the output register unless i_pop stalls;
    // it loads a queued next request in the same cycle it emits the current last byte.
    tslne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (fifo_cmd),
        .i_fifo_stat (fifo_stat),
        .o_cmd_pop   (back_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    assign o_full = fifo_stat.full;

endmodule

// ===== rtl/tslne_checker.sv =====
// Port-level checker for the text filter, bound to the top level.
module tslne_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_push,
    input logic       o_full,
    input logic       i_pop,
    input logic       o_empty,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    // squeezed newlines are accepted but make no result, so only
    // "some request was taken since reset" can be tracked from the ports
    logic r_seen_req;
    logic in_acc;

    assign in_acc = i_push & ~o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_req <= 1'b0;
        end else if (in_acc) begin
            r_seen_req <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("input side full after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_byte) && $stable(o_last)))
        else $error("stalled result changed");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> r_seen_req)
        else $error("result shown with no request taken");

endmodule

bind text_stream_line_number_escaper tslne_props u_chk (.*);

// ===== tb/sv/tslne_checker.sv =====
// Scoreboard for the line-number / escape filter: tracks config, predicts each request, checks results.
`timescale 1ns / 1ps
module tslne_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [tslne_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tslne_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_push,
    input  logic                                i_full,
    input  logic [7:0]                          i_in_byte,
    input  logic                                i_empty,
    input  logic                                i_pop,
    input  logic [7:0]                          i_out_byte,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import tslne_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_char_t;

    localparam logic [BCD_W-1:0] LINE_CNT_MAX = {NUMBER_DIGITS{4'h9}};

    out_char_t        expansion_q[$];
    logic [7:0]       run_buf [0:15];
    int               run_len;

    logic [1:0]       num_mode;
    logic             squeeze_on;
    logic             ends_on;
    logic             tabs_on;
    logic             nonprint_on;

    logic [BCD_W-1:0] line_cnt;
    logic             at_start;
    logic [1:0]       empty_lines;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // saturating decimal increment, stays at all nines
    function automatic logic [BCD_W-1:0] next_line_cnt(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        int               k;
        r     = v;
        carry = 1'b1;
        if (v == LINE_CNT_MAX) return v;
        for (k = 0; k < NUMBER_DIGITS; k++) begin
            if (carry) begin
                if (r[4*k +: 4] == 4'h9) begin
                    r[4*k +: 4] = 4'h0;
                end else begin
                    r[4*k +: 4] = r[4*k +: 4] + 4'h1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    task automatic add_char(input logic [7:0] ch);
        run_buf[run_len] = ch;
        run_len++;
    endtask

    task automatic predict_expansion(input logic [7:0] c);
        logic      is_nl;
        logic      every;
        logic      printable;
        logic      started;
        logic [3:0] d;
        int        k;
        out_char_t e;
        run_len = 0;
        is_nl   = (c == CH_NL);
        if (!is_nl) begin
            empty_lines = 2'd0;
        end else if (at_start && empty_lines < 2'd2) begin
            empty_lines = empty_lines + 2'd1;
        end

        // a second or later empty line in a row vanishes when squeezing
        if (!(squeeze_on && empty_lines >= 2'd2)) begin
            every = (num_mode != NUM_OFF) && (num_mode != NUM_NONBLANK);
            if (at_start && (every || (num_mode == NUM_NONBLANK && empty_lines == 2'd0))) begin
                started = 1'b0;
                for (k = NUMBER_DIGITS - 1; k >= 0; k--) begin
                    d       = line_cnt[4*k +: 4];
                    started = started | (d != 4'h0) | (k == 0);
                    add_char(started ? (CH_ZERO + {4'h0, d}) : CH_SPACE);
                end
                add_char(CH_TAB);
                line_cnt = next_line_cnt(line_cnt);
            end
            printable = (c >= CH_SPACE && c <= CH_TILDE) || is_nl || c == CH_TAB;
            if (nonprint_on && !printable) begin
                if (c >= CH_HIGH) begin
                    add_char(CH_M);
                    add_char(CH_DASH);
                end
                if (c == CH_FF || c == CH_DEL) begin
                    add_char(CH_CARET);
                    add_char(CH_QMARK);
                end else if (c >= CH_MHIGH) begin
                    add_char(c - CH_HIGH);
                end else if (c >= CH_HIGH) begin
                    add_char(CH_CARET);
                    add_char(c - OFS_CTRL);
                end else begin
                    add_char(CH_CARET);
                    add_char(c + OFS_CTRL);
                end
            end else begin
                if (ends_on && is_nl) add_char(CH_DOLLAR);
                if (tabs_on && c == CH_TAB) begin
                    add_char(CH_CARET);
                    add_char(CH_I);
                end else begin
                    add_char(c);
                end
            end
        end
        at_start = is_nl;

        for (k = 0; k < run_len; k++) begin
            e.ch   = run_buf[k];
            e.last = (k == run_len - 1);
            expansion_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        out_char_t got;
        if (!i_rst_n) begin
            num_mode    = NUM_OFF;
            squeeze_on  = 1'b0;
            ends_on     = 1'b0;
            tabs_on     = 1'b0;
            nonprint_on = 1'b0;
            line_cnt    = {{(BCD_W-4){1'b0}}, 4'h1};
            at_start    = 1'b1;
            empty_lines = 2'd0;
            expansion_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_NUMBER_MODE:      num_mode    = i_cfg_data;
                    REG_SQUEEZE_EMPTY:    squeeze_on  = i_cfg_data[0];
                    REG_SHOW_ENDS:        ends_on     = i_cfg_data[0];
                    REG_SHOW_TABS:        tabs_on     = i_cfg_data[0];
                    REG_SHOW_NONPRINTING: nonprint_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (expansion_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %02h last %0b",
                                              i_out_byte, i_last));
                end else begin
                    got = expansion_q.pop_front();
                    if (i_out_byte !== got.ch)
                        report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                                  i_out_byte, got.ch));
                    if (i_last !== got.last)
                        report_mismatch($sformatf("last %0b, predicted %0b on byte %02h",
                                                  i_last, got.last, got.ch));
                end
            end
            if (i_push && !i_full) predict_expansion(i_in_byte);
        end
        o_pending = expansion_q.size();
    end

endmodule

// ===== tb/sv/tb_text_stream_line_number_escaper.sv =====
// Top of the line-number / escape filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_text_stream_line_number_escaper;
    import tslne_pkg::*;

    // modes the package leaves unnamed: 3 behaves as "every line"
    localparam logic [1:0]           NUM_EVERY     = 2'd1;
    localparam logic [1:0]           NUM_EVERY_ALT = 2'd3;
    // an index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;
    // margin for results still passing through the request queue and output register
    localparam int                   SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {POP_ALWAYS, POP_RANDOM, POP_SPARSE} pop_style_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_push;
    logic                  o_full;
    logic [7:0]            i_in_byte;
    logic                  o_empty;
    logic                  i_pop = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_last;

    int                    fail_count;
    int                    pending;
    int                    burst_left = 0;
    int                    pop_cycle  = 0;
    pop_style_t            pop_style  = POP_ALWAYS;

    text_stream_line_number_escaper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in_byte   (i_in_byte),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    tslne_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (i_push),
        .i_full       (o_full),
        .i_in_byte    (i_in_byte),
        .i_empty      (o_empty),
        .i_pop        (i_pop),
        .i_out_byte   (o_out_byte),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: a randomly drawn stall style decides whether each stretch
    // pops at full rate, at random, or sparsely.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (pop_cycle % 64 == 0) pop_style = pop_style_t'($urandom_range(0, 2));
            case (pop_style)
                POP_ALWAYS: i_pop <= 1'b1;
                POP_RANDOM: i_pop <= 1'($urandom_range(0, 1));
                default:    i_pop <= (pop_cycle % 4 == 0);
            endcase
            pop_cycle++;
        end
    end

    // Mostly text-like content: plenty of newlines so empty-line runs and
    // line starts show up often, some tabs, and a share of arbitrary bytes
    // so every bit of the input toggles.
    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)      return CH_NL;
        else if (r < 30) return CH_TAB;
        else if (r < 45) return 8'($urandom_range(0, 255));
        else             return 8'($urandom_range(32, 126));
    endfunction

    // Push one request. The sender works in bursts of 1..16 requests with a
    // random idle gap, possibly none, before each burst; push stays high inside a
    // burst and holds through back-pressure until the request is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_push <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        i_push    <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_full);
        burst_left--;
    endtask

    // Drop push, wait for every predicted byte to come out, then give the
    // pipeline time to settle before the next step.
    task automatic wait_idle();
        @(negedge i_clk);
        i_push     <= 1'b0;
        burst_left  = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
    endtask

    // Writes every register plus one stray index. One-bit registers may get
    // 2 or 3 here; only bit 0 is supposed to stick.
    task automatic set_config(input logic [1:0] mode, input logic [1:0] sq,
                              input logic [1:0] ends, input logic [1:0] tabs,
                              input logic [1:0] np);
        write_reg(REG_NUMBER_MODE, mode);
        write_reg(REG_SQUEEZE_EMPTY, sq);
        write_reg(REG_SHOW_ENDS, ends);
        write_reg(REG_SHOW_TABS, tabs);
        write_reg(REG_SHOW_NONPRINTING, np);
        write_reg(REG_UNUSED, 2'($urandom_range(0, 3)));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [1:0] mode, input logic [1:0] sq,
                             input logic [1:0] ends, input logic [1:0] tabs,
                             input logic [1:0] np);
        wait_idle();
        set_config(mode, sq, ends, tabs, np);
        repeat (23) send_byte(text_byte());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_NUMBER_MODE;
        i_cfg_data  = '0;
        i_push      = 1'b0;
        i_in_byte   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: everything passes through untouched
        send_byte("A");
        send_byte(CH_TAB);
        send_byte(CH_NL);
        send_byte(CH_NL);

        // all options on, every line numbered: byte class edges, then a run
        // of empty lines long enough to be squeezed
        wait_idle();
        set_config(NUM_EVERY, 2'd1, 2'd1, 2'd1, 2'd1);
        send_byte("x");
        send_byte(8'h00);
        send_byte(CH_TAB);
        send_byte(8'h1F);
        send_byte(CH_SPACE);
        send_byte(CH_TILDE);
        send_byte(CH_DEL);
        send_byte(CH_HIGH);
        send_byte(8'h9F);
        send_byte(CH_MHIGH);
        send_byte(8'hFE);
        send_byte(CH_FF);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte("y");
        send_byte(CH_NL);

        // random text under a spread of settings
        run_phase(NUM_NONBLANK,  2'd1, 2'd0, 2'd1, 2'd0);
        run_phase(NUM_EVERY_ALT, 2'd0, 2'd1, 2'd0, 2'd1);
        run_phase(NUM_OFF,       2'd3, 2'd2, 2'd3, 2'd2);
        run_phase(NUM_NONBLANK,  2'd0, 2'd1, 2'd1, 2'd1);
        run_phase(NUM_EVERY,     2'd1, 2'd3, 2'd0, 2'd1);
        run_phase(NUM_OFF,       2'd0, 2'd0, 2'd0, 2'd0);

        wait_idle();
        if (fail_count == 0) begin
            $display("text_stream_line_number_escaper: match");
        end else begin
            $display("text_stream_line_number_escaper: mismatch");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("text_stream_line_number_escaper: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tslne_pkg.sv
rtl/tslne_front.sv
rtl/tslne_cmd_fifo.sv
rtl/tslne_back.sv
rtl/text_stream_line_number_escaper.sv
rtl/tslne_checker.sv
tb/sv/tslne_checker.sv
tb/sv/tb_text_stream_line_number_escaper.sv
